// ===== sv/acps_pkg.sv =====
// types, codes and defaults shared by the collision pair scanner
package acps_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MASK_W        = 64;
  localparam int KIND_W        = 3;
  localparam int SLOT_FIELD_W  = 3;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SCAN   = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    RESP_ADDED   = 3'd0,
    RESP_FULL    = 3'd1,
    RESP_REMOVED = 3'd2,
    RESP_PAIR    = 3'd3,
    RESP_DONE    = 3'd4
  } resp_kind_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [15:0]      rect_x;
    logic signed [15:0]      rect_y;
    logic [14:0]             rect_w;
    logic [14:0]             rect_h;
    logic [KIND_W-1:0]       collider_kind;
    logic                    wants_notify;
    logic [SLOT_FIELD_W-1:0] target_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]              resp_kind;
    logic [SLOT_FIELD_W-1:0] slot_first;
    logic [SLOT_FIELD_W-1:0] slot_second;
    logic                    notify_first;
    logic                    notify_second;
    logic                    last_result;
  } resp_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [KIND_W-1:0]  kind;
    logic               notify;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic notify_a;
    logic notify_b;
  } pair_res_t;

endpackage

// ===== sv/acps_chan_if.sv =====
// valid/ready channel carrying one request or result
interface acps_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/acps_pair_test.sv =====
// overlap and notify test for one pair of stored rectangles
module acps_pair_test (
  input  acps_pkg::entry_t              entry_a,
  input  acps_pkg::entry_t              entry_b,
  input  logic [acps_pkg::MASK_W-1:0]   notify_mask,
  output acps_pkg::pair_res_t           res
);
  import acps_pkg::*;

  logic signed [16:0] a_left, a_right, a_top, a_bottom;
  logic signed [16:0] b_left, b_right, b_top, b_bottom;
  logic [2*KIND_W-1:0] bit_ab, bit_ba;

  assign a_left   = {entry_a.left[15], entry_a.left};
  assign a_top    = {entry_a.top[15], entry_a.top};
  assign a_right  = a_left + $signed({2'b00, entry_a.width});
  assign a_bottom = a_top + $signed({2'b00, entry_a.height});
  assign b_left   = {entry_b.left[15], entry_b.left};
  assign b_top    = {entry_b.top[15], entry_b.top};
  assign b_right  = b_left + $signed({2'b00, entry_b.width});
  assign b_bottom = b_top + $signed({2'b00, entry_b.height});

  assign bit_ab = {entry_a.kind, entry_b.kind};
  assign bit_ba = {entry_b.kind, entry_a.kind};

  assign res.hit      = (a_left < b_right) && (a_right > b_left) &&
                        (a_top < b_bottom) && (a_bottom > b_top);
  assign res.notify_a = notify_mask[bit_ab] & entry_a.notify;
  assign res.notify_b = notify_mask[bit_ba] & entry_b.notify;

endmodule

// ===== sv/aabb_collision_pair_scanner.sv =====
// Collider table with pairwise overlap scan. Add and remove requests each
// give one result. A scan request walks all NUM_SLOTS*(NUM_SLOTS-1)/2 slot
// pairs in order, one pair per cycle while the result side does not stall,
// through a single overlap unit fed by the two registered read ports of the
// collider memory; no new request is taken until the scan done result is out.
module aabb_collision_pair_scanner #(
  parameter int NUM_SLOTS = acps_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  acps_chan_if.sink                   in_req,
  acps_chan_if.source                 out_resp,
  input  logic                        cfg_we,
  input  logic [acps_pkg::MASK_W-1:0] cfg_wdata
);
  import acps_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PAIRS = 4'b0010,
    ST_DONE  = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [MASK_W-1:0]   mask_r;
  logic [NUM_SLOTS-1:0] slot_used_r, slot_used_nxt;
  logic [SW-1:0]       iss_i_r, iss_i_nxt, iss_k_r, iss_k_nxt;
  logic                s1_valid_r, s1_done_r;
  logic [SW-1:0]       s1_i_r, s1_k_r;
  entry_t              mem [NUM_SLOTS];
  entry_t              rd_a_r, rd_b_r, new_entry;
  logic                out_valid_r, out_valid_nxt;
  resp_t               out_r, out_nxt;
  req_t                req;
  pair_res_t           pair_res;
  logic                adv, accept, pair_hit, last_pair, free_found, mem_we;
  logic [SW-1:0]       free_idx, rm_idx;

  assign req     = in_req.payload;
  assign adv     = !out_valid_r || out_resp.ready;
  assign in_req.ready = (state_r == ST_IDLE) && adv;
  assign accept  = in_req.valid && in_req.ready;
  assign out_resp.valid   = out_valid_r;
  assign out_resp.payload = out_r;

  assign last_pair = (iss_k_r == SW'(NUM_SLOTS - 1)) && (iss_i_r == SW'(NUM_SLOTS - 2));
  assign rm_idx    = SW'(req.target_slot);
  assign mem_we    = accept && (req.req_type == REQ_ADD) && free_found;

  assign new_entry.left   = req.rect_x;
  assign new_entry.top    = req.rect_y;
  assign new_entry.width  = req.rect_w;
  assign new_entry.height = req.rect_h;
  assign new_entry.kind   = req.collider_kind;
  assign new_entry.notify = req.wants_notify;

  acps_pair_test u_pair_test (
    .entry_a     (rd_a_r),
    .entry_b     (rd_b_r),
    .notify_mask (mask_r),
    .res         (pair_res)
  );

  assign pair_hit = s1_valid_r && !s1_done_r && slot_used_r[s1_i_r] &&
                    slot_used_r[s1_k_r] && pair_res.hit &&
                    (pair_res.notify_a || pair_res.notify_b);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (!slot_used_r[j]) begin
        free_found = 1'b1;
        free_idx   = SW'(j);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    iss_i_nxt     = iss_i_r;
    iss_k_nxt     = iss_k_r;
    slot_used_nxt = slot_used_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
      out_nxt       = '0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (req.req_type)
              REQ_ADD: begin
                out_valid_nxt       = 1'b1;
                out_nxt.last_result = 1'b1;
                if (free_found) begin
                  out_nxt.resp_kind       = RESP_ADDED;
                  out_nxt.slot_first      = SLOT_FIELD_W'(free_idx);
                  slot_used_nxt[free_idx] = 1'b1;
                end else begin
                  out_nxt.resp_kind = RESP_FULL;
                end
              end
              REQ_REMOVE: begin
                out_valid_nxt       = 1'b1;
                out_nxt.last_result = 1'b1;
                out_nxt.resp_kind   = RESP_REMOVED;
                out_nxt.slot_first  = req.target_slot;
                if (32'(req.target_slot) < NUM_SLOTS) begin
                  slot_used_nxt[rm_idx] = 1'b0;
                end
              end
              REQ_SCAN: begin
                state_nxt = ST_PAIRS;
                iss_i_nxt = '0;
                iss_k_nxt = SW'(1);
              end
              default: ;
            endcase
          end
        end
        ST_PAIRS: begin
          if (last_pair) begin
            state_nxt = ST_DONE;
          end else if (iss_k_r == SW'(NUM_SLOTS - 1)) begin
            iss_i_nxt = iss_i_r + SW'(1);
            iss_k_nxt = iss_i_r + SW'(2);
          end else begin
            iss_k_nxt = iss_k_r + SW'(1);
          end
        end
        ST_DONE: begin
          state_nxt = ST_WAIT;
        end
        ST_WAIT: begin
          state_nxt = ST_IDLE;
        end
        default: state_nxt = ST_IDLE;
      endcase
      // results of the pair stage
      if (s1_valid_r && s1_done_r) begin
        out_valid_nxt       = 1'b1;
        out_nxt.resp_kind   = RESP_DONE;
        out_nxt.last_result = 1'b1;
      end else if (pair_hit) begin
        out_valid_nxt         = 1'b1;
        out_nxt.resp_kind     = RESP_PAIR;
        out_nxt.slot_first    = SLOT_FIELD_W'(s1_i_r);
        out_nxt.slot_second   = SLOT_FIELD_W'(s1_k_r);
        out_nxt.notify_first  = pair_res.notify_a;
        out_nxt.notify_second = pair_res.notify_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= '0;
      slot_used_r <= '0;
      out_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s1_done_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_used_r <= slot_used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      if (adv) begin
        s1_valid_r <= (state_r == ST_PAIRS) || (state_r == ST_DONE);
        s1_done_r  <= (state_r == ST_DONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_i_r <= iss_i_nxt;
    iss_k_r <= iss_k_nxt;
    out_r   <= out_nxt;
    if (adv) begin
      s1_i_r <= iss_i_r;
      s1_k_r <= iss_k_r;
    end
  end

  // collider memory, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_idx] <= new_entry;
    end
    if (adv) begin
      rd_a_r <= mem[iss_i_r];
      rd_b_r <= mem[iss_k_r];
    end
  end

`ifndef SYNTHESIS
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.resp_kind == RESP_PAIR) |-> (out_r.slot_first < out_r.slot_second))
    else $error("pair result with unordered slots");

  a_pair_told: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.resp_kind == RESP_PAIR) |->
      ((out_r.notify_first || out_r.notify_second) && !out_r.last_result))
    else $error("pair result with no side told or marked last");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !s1_valid_r)
    else $error("pair stage busy while idle");

  a_used_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && $past(state_r) != ST_IDLE) |-> $stable(slot_used_r))
    else $error("slot table changed during scan");
`endif

endmodule

// ===== verif/tb_top.sv =====
// testbench for the collider table and overlap pair scanner
module tb_top;
  import acps_pkg::*;

  localparam int SLOTS      = NUM_SLOTS_DEF;
  localparam int SETTLE     = 40;
  localparam int STALL_MAX  = 3000;
  localparam int HOLD_LONG  = 300;

  class collider_scoreboard;
    logic [MASK_W-1:0] mask;
    bit                used [SLOTS];
    entry_t            slots [SLOTS];
    resp_t             expected_resps [$];
    int                errors;

    function new();
      mask   = '0;
      errors = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function int pending();
      return expected_resps.size();
    endfunction

    function void push_result(resp_kind_t k, int s1, int s2, bit n1, bit n2, bit last);
      resp_t e;
      e.resp_kind     = k;
      e.slot_first    = s1[SLOT_FIELD_W-1:0];
      e.slot_second   = s2[SLOT_FIELD_W-1:0];
      e.notify_first  = n1;
      e.notify_second = n2;
      e.last_result   = last;
      expected_resps.push_back(e);
    endfunction

    function bit overlaps(int a, int b);
      int al, at, aw, ah, bl, bt, bw, bh;
      al = $signed(slots[a].left);
      at = $signed(slots[a].top);
      aw = slots[a].width;
      ah = slots[a].height;
      bl = $signed(slots[b].left);
      bt = $signed(slots[b].top);
      bw = slots[b].width;
      bh = slots[b].height;
      return (al < bl + bw) && (al + aw > bl) && (at < bt + bh) && (at + ah > bt);
    endfunction

    function bit told(int self_slot, int other_slot);
      return mask[{slots[self_slot].kind, slots[other_slot].kind}] & slots[self_slot].notify;
    endfunction

    function void note_request(req_t r);
      int free_slot;
      bit n1, n2;
      free_slot = -1;
      case (r.req_type)
        REQ_ADD: begin
          for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) free_slot = i;
          if (free_slot < 0) begin
            push_result(RESP_FULL, 0, 0, 0, 0, 1);
          end else begin
            used[free_slot]         = 1'b1;
            slots[free_slot].left   = r.rect_x;
            slots[free_slot].top    = r.rect_y;
            slots[free_slot].width  = r.rect_w;
            slots[free_slot].height = r.rect_h;
            slots[free_slot].kind   = r.collider_kind;
            slots[free_slot].notify = r.wants_notify;
            push_result(RESP_ADDED, free_slot, 0, 0, 0, 1);
          end
        end
        REQ_REMOVE: begin
          if (r.target_slot < SLOTS) used[r.target_slot] = 1'b0;
          push_result(RESP_REMOVED, r.target_slot, 0, 0, 0, 1);
        end
        REQ_SCAN: begin
          for (int i = 0; i < SLOTS; i++) begin
            for (int k = i + 1; k < SLOTS; k++) begin
              if (used[i] && used[k] && overlaps(i, k)) begin
                n1 = told(i, k);
                n2 = told(k, i);
                if (n1 || n2) push_result(RESP_PAIR, i, k, n1, n2, 0);
              end
            end
          end
          push_result(RESP_DONE, 0, 0, 0, 0, 1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(resp_t got);
      resp_t exp;
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
      end else begin
        exp = expected_resps.pop_front();
        if (got !== exp) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, exp, got);
          errors++;
        end
      end
    endfunction
  endclass

  bit                clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [MASK_W-1:0] cfg_wdata = '0;

  int in_idle_pct  = 21;
  int out_idle_pct = 21;
  int hold_cycles  = 0;
  int quiet_cycles = 0;

  collider_scoreboard sb = new();

  acps_chan_if #(.payload_t(req_t))  req_if ();
  acps_chan_if #(.payload_t(resp_t)) resp_if ();

  aabb_collision_pair_scanner u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if.sink),
    .out_resp  (resp_if.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    resp_if.ready  = 1'b0;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      resp_if.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      resp_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (req_if.valid && req_if.ready) sb.note_request(req_if.payload);
    if (resp_if.valid && resp_if.ready) sb.check_result(resp_if.payload);
    if ((req_if.valid && req_if.ready) || (resp_if.valid && resp_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, sb.pending());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_request(req_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    // let the last accepted request reach the scoreboard
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mask(logic [MASK_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sb.mask = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_rect(int x, int y, int w, int h, int k, bit n);
    req_t r;
    r               = '0;
    r.req_type      = REQ_ADD;
    r.rect_x        = x[15:0];
    r.rect_y        = y[15:0];
    r.rect_w        = w[14:0];
    r.rect_h        = h[14:0];
    r.collider_kind = k[KIND_W-1:0];
    r.wants_notify  = n;
    send_request(r);
  endtask

  task automatic simple_request(req_type_t t, int s);
    req_t r;
    r             = '0;
    r.req_type    = t;
    r.target_slot = s[SLOT_FIELD_W-1:0];
    send_request(r);
  endtask

  function automatic req_t random_request();
    req_t        r;
    int          pick;
    logic [95:0] raw;
    raw  = {$urandom, $urandom, $urandom};
    r    = raw[$bits(req_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.req_type = REQ_ADD;
      // mostly a crowded region so that scans find pairs
      if ($urandom_range(99) < 85) begin
        r.rect_x = 16'($urandom_range(400) - 200);
        r.rect_y = 16'($urandom_range(400) - 200);
        r.rect_w = 15'($urandom_range(150));
        r.rect_h = 15'($urandom_range(150));
      end
    end else if (pick < 70) begin
      r.req_type = REQ_REMOVE;
    end else if (pick < 94) begin
      r.req_type = REQ_SCAN;
    end else begin
      r.req_type = REQ_NONE;
    end
    return r;
  endfunction

  task automatic random_phase(int n_items);
    req_t r;
    int   sent;
    sent = 0;
    while (sent < n_items) begin
      r = random_request();
      send_request(r);
      if (r.req_type != REQ_NONE) sent++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mask('1);

    add_rect(-32768, -32768, 32767, 32767, 7, 1);
    add_rect(32767, 32767, 32767, 32767, 0, 1);
    add_rect(-10, -10, 20, 20, 3, 1);
    // edges touching only
    add_rect(10, -10, 5, 5, 5, 0);
    // zero width and zero height inside another rectangle
    add_rect(0, 0, 0, 10, 1, 1);
    add_rect(0, 0, 10, 0, 2, 1);
    // overlapping pair with nobody told
    add_rect(1000, 1000, 50, 50, 4, 0);
    add_rect(1020, 1020, 50, 50, 6, 0);
    add_rect(5, 5, 5, 5, 2, 1);
    simple_request(REQ_SCAN, 0);
    simple_request(REQ_REMOVE, 3);
    simple_request(REQ_REMOVE, 3);
    add_rect(1005, 1005, 10, 10, 5, 1);
    simple_request(REQ_SCAN, 0);
    simple_request(REQ_NONE, 5);
    simple_request(REQ_REMOVE, 0);
    simple_request(REQ_REMOVE, 7);
    simple_request(REQ_SCAN, 0);
    drain_results();

    write_mask('0);
    simple_request(REQ_SCAN, 0);
    add_rect(-5, -5, 30, 30, 3, 1);
    simple_request(REQ_SCAN, 0);
    drain_results();

    write_mask({$urandom, $urandom});
    random_phase(40);
    drain_results();

    // stretch with no idling on either side
    write_mask(64'hAAAA_5555_AAAA_5555);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    random_phase(30);
    drain_results();

    write_mask({$urandom, $urandom});
    in_idle_pct  = 21;
    out_idle_pct = 21;
    hold_cycles  = HOLD_LONG;
    for (int i = 0; i < 6; i++) begin
      add_rect(-20 + 4 * i, -20, 40, 40, i, 1);
      simple_request(REQ_SCAN, 0);
    end
    random_phase(40);
    drain_results();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
